@@ rtl/sgba_pkg.sv @@
// Shared constants and types for the sliding GC bias averager.
// No dependencies; imported by sgba_front, sgba_back, sgba_checker and the top module.
package sgba_pkg;

    localparam int MAX_K_DEF      = 64;
    localparam int COUNT_BITS_DEF = 24;
    localparam int MEAN_W         = 16;
    localparam int WLEN_W         = 7;
    localparam int TIDX_W         = 7;
    localparam int WLEN_RESET     = 25;
    localparam int FIFO_DEPTH     = 4;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic REQ_TABLE = 1'b0;
    localparam logic REQ_BASE  = 1'b1;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    localparam logic REG_WINDOW_LEN = 1'b0;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_DIV  = 3'b010,
        BK_DONE = 3'b100
    } back_state_t;

endpackage

@@ rtl/sgba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sgba_queue.sv @@
// Small FIFO between front and back end; holds finished per-sequence sums.
// Depends on nothing but its parameters.
module sgba_queue #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           head_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = slot_reg[rd_ptr_reg];
    assign empty     = (count_reg == '0);
    assign count     = count_reg;

endmodule

@@ rtl/sgba_front.sv @@
// Front end: takes requests, keeps the GC window, looks up bias and accumulates.
// Depends on sgba_pkg and sgba_ram.
module sgba_front
    import sgba_pkg::*;
#(
    parameter int MAX_K      = MAX_K_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [$clog2(MAX_K+1)-1:0]           k_eff,
    input  logic                                 clear,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic                                 req_type,
    input  logic [TIDX_W-1:0]                    table_index,
    input  logic [MEAN_W-1:0]                    table_value,
    input  logic [1:0]                           base_code,
    input  logic                                 seq_last,
    input  logic [$clog2(FIFO_DEPTH+1)-1:0]      q_count,
    output logic                                 push,
    output logic [MEAN_W+COUNT_BITS-1:0]         push_sum,
    output logic [COUNT_BITS-1:0]                push_count,
    output logic                                 push_sat
);

    localparam int KW  = $clog2(MAX_K + 1);
    localparam int KIW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CB  = COUNT_BITS;
    localparam int SW  = MEAN_W + COUNT_BITS;
    localparam int QCW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

    logic [MAX_K-1:0] win_reg, win_next;
    logic [KW-1:0]    gc_reg, gc_next;
    logic [KW-1:0]    seen_reg, seen_next;
    logic [CB-1:0]    wd_reg, wd_next;

    logic             s2_valid_reg;
    logic             s2_add_reg;
    logic             s2_last_reg;
    logic [CB-1:0]    s2_count_reg;
    logic             s2_sat_reg;
    logic [SW-1:0]    sum_reg, sum_next;

    logic             accept;
    logic             base_acc;
    logic             tbl_we;
    logic             gc_bit;
    logic             drop;
    logic [KW-1:0]    gc_upd;
    logic [KW-1:0]    seen_upd;
    logic             add_win;
    logic [CB-1:0]    wd_upd;
    logic [MEAN_W-1:0] bias_rdata;
    logic [SW-1:0]    sum_total;

    assign item_stall = ((QCW + 1)'(q_count) + (QCW + 1)'(s2_valid_reg && s2_last_reg))
                        >= (QCW + 1)'(FIFO_DEPTH);
    assign accept   = item_valid && !item_stall;
    assign base_acc = accept && (req_type == REQ_BASE);
    assign tbl_we   = accept && (req_type == REQ_TABLE)
                      && (32'(table_index) <= 32'(MAX_K));

    always_comb
    begin
        gc_bit   = (base_code == BASE_C) || (base_code == BASE_G);
        drop     = (seen_reg >= k_eff) && win_reg[KIW'(k_eff - 1'b1)];
        gc_upd   = gc_reg - KW'(drop) + KW'(gc_bit);
        seen_upd = seen_reg + KW'(seen_reg < k_eff);
        add_win  = (seen_upd >= k_eff) && (wd_reg != CNT_MAX);
        wd_upd   = wd_reg + CB'(add_win);

        win_next  = win_reg;
        gc_next   = gc_reg;
        seen_next = seen_reg;
        wd_next   = wd_reg;
        if (clear)
        begin
            win_next  = '0;
            gc_next   = '0;
            seen_next = '0;
            wd_next   = '0;
        end
        else if (base_acc)
        begin
            if (seq_last)
            begin
                win_next  = '0;
                gc_next   = '0;
                seen_next = '0;
                wd_next   = '0;
            end
            else
            begin
                win_next  = MAX_K'({win_reg, gc_bit});
                gc_next   = gc_upd;
                seen_next = seen_upd;
                wd_next   = wd_upd;
            end
        end
    end

    sgba_ram #(
        .WIDTH (MEAN_W),
        .DEPTH (MAX_K + 1)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (KW'(table_index)),
        .wdata (table_value),
        .re    (base_acc),
        .raddr (gc_upd),
        .rdata (bias_rdata)
    );

    assign sum_total = sum_reg + (s2_add_reg ? SW'(bias_rdata) : '0);

    always_comb
    begin
        sum_next = sum_reg;
        if (clear)
        begin
            sum_next = '0;
        end
        else if (s2_valid_reg)
        begin
            sum_next = s2_last_reg ? '0 : sum_total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '0;
            gc_reg       <= '0;
            seen_reg     <= '0;
            wd_reg       <= '0;
            sum_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg      <= win_next;
            gc_reg       <= gc_next;
            seen_reg     <= seen_next;
            wd_reg       <= wd_next;
            sum_reg      <= sum_next;
            s2_valid_reg <= base_acc && !clear;
        end
    end

    always_ff @(posedge clk)
    begin
        if (base_acc)
        begin
            s2_add_reg   <= add_win;
            s2_last_reg  <= seq_last;
            s2_count_reg <= wd_upd;
            s2_sat_reg   <= (wd_upd == CNT_MAX);
        end
    end

    assign push       = s2_valid_reg && s2_last_reg;
    assign push_sum   = sum_total;
    assign push_count = s2_count_reg;
    assign push_sat   = s2_sat_reg;

endmodule

@@ rtl/sgba_back.sv @@
// Back end: pops a sequence total, divides by the window count, holds the result.
// Depends on sgba_pkg.
module sgba_back
    import sgba_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  logic [MEAN_W+COUNT_BITS-1:0]  head_sum,
    input  logic [COUNT_BITS-1:0]         head_count,
    input  logic                          head_sat,
    output logic                          pop,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [MEAN_W-1:0]             bias_mean,
    output logic [COUNT_BITS-1:0]         window_count,
    output logic                          too_short,
    output logic                          count_saturated
);

    localparam int CB = COUNT_BITS;
    localparam int SW = MEAN_W + COUNT_BITS;
    localparam int STW = $clog2(MEAN_W);

    back_state_t      state_reg, state_next;
    logic [CB-1:0]    rem_reg;
    logic [MEAN_W-1:0] quo_reg;
    logic [CB-1:0]    div_reg;
    logic [STW-1:0]   step_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [CB-1:0]    cnt_reg;
    logic             short_reg;
    logic             sat_reg;

    logic [CB:0]      trial;
    logic             ge;
    logic [CB:0]      diff;
    logic [CB-1:0]    rem_next;
    logic [MEAN_W-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[MEAN_W-1]};
        ge       = trial >= {1'b0, div_reg};
        diff     = trial - {1'b0, div_reg};
        rem_next = ge ? diff[CB-1:0] : trial[CB-1:0];
        quo_next = {quo_reg[MEAN_W-2:0], ge};
    end

    assign pop = (state_reg == BK_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (head_count == '0) ? BK_DONE : BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (step_reg == STW'(MEAN_W - 1))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!result_stall)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    rem_reg   <= head_sum[SW-1:MEAN_W];
                    quo_reg   <= head_sum[MEAN_W-1:0];
                    div_reg   <= head_count;
                    step_reg  <= '0;
                    cnt_reg   <= head_count;
                    sat_reg   <= head_sat;
                    short_reg <= (head_count == '0);
                    mean_reg  <= '0;
                end
            end
            BK_DIV:
            begin
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
                step_reg <= step_reg + 1'b1;
                if (step_reg == STW'(MEAN_W - 1))
                begin
                    mean_reg <= quo_next;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid    = (state_reg == BK_DONE);
    assign bias_mean       = mean_reg;
    assign window_count    = cnt_reg;
    assign too_short       = short_reg;
    assign count_saturated = sat_reg;

endmodule

@@ rtl/sliding_gc_bias_average.sv @@
// Channel   Handshake                  Payload
// item      item_valid / item_stall    req_type table_index table_value base_code seq_last
// result    result_valid / result_stall bias_mean window_count too_short count_saturated
// config    APB psel/penable/pwrite    paddr pwdata -> prdata (window_len at 0x0)
//
// Items are taken one per cycle unless item_stall is high; the table read registers at
// acceptance, the sum in the cycle after, and a sequence total is pushed in the cycle
// after its last base. In the back end each result passes a pop, 16 divide steps of one
// quotient bit each and an output hold; a sequence with no window skips the divide and
// goes from pop to hold. A 4-entry queue buffers sequence totals.
// item_stall rises when the queued totals plus one about to be pushed fill the queue;
// result_stall holds the result. rst_n clears control state; the bias table has no reset.
// Depends on sgba_pkg, sgba_front, sgba_queue, sgba_back, sgba_ram.
module sliding_gc_bias_average
    import sgba_pkg::*;
#(
    parameter int MAX_K      = MAX_K_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic                   req_type,
    input  logic [TIDX_W-1:0]      table_index,
    input  logic [MEAN_W-1:0]      table_value,
    input  logic [1:0]             base_code,
    input  logic                   seq_last,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [MEAN_W-1:0]      bias_mean,
    output logic [COUNT_BITS-1:0]  window_count,
    output logic                   too_short,
    output logic                   count_saturated
);

    localparam int KW  = $clog2(MAX_K + 1);
    localparam int SW  = MEAN_W + COUNT_BITS;
    localparam int QW  = SW + COUNT_BITS + 1;
    localparam int QCW = $clog2(FIFO_DEPTH + 1);

    function automatic logic [KW-1:0] eff_k(input logic [WLEN_W-1:0] v);
        logic [KW-1:0] k;
        begin
            if (v == '0)
            begin
                k = KW'(1);
            end
            else if (32'(v) > 32'(MAX_K))
            begin
                k = KW'(MAX_K);
            end
            else
            begin
                k = KW'(v);
            end
            return k;
        end
    endfunction

    logic [WLEN_W-1:0] wlen_reg;
    logic [KW-1:0]     keff_reg;
    logic              cfg_wr;

    logic              push;
    logic [SW-1:0]     push_sum;
    logic [COUNT_BITS-1:0] push_count;
    logic              push_sat;
    logic              pop;
    logic              q_empty;
    logic [QCW-1:0]    q_count;
    logic [QW-1:0]     head_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LEN);
    assign prdata = (paddr[2] == REG_WINDOW_LEN) ? APB_DATA_W'(wlen_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WLEN_W'(WLEN_RESET);
            keff_reg <= eff_k(WLEN_W'(WLEN_RESET));
        end
        else if (cfg_wr)
        begin
            wlen_reg <= pwdata[WLEN_W-1:0];
            keff_reg <= eff_k(pwdata[WLEN_W-1:0]);
        end
    end

    sgba_front #(
        .MAX_K      (MAX_K),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .k_eff       (keff_reg),
        .clear       (cfg_wr),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .req_type    (req_type),
        .table_index (table_index),
        .table_value (table_value),
        .base_code   (base_code),
        .seq_last    (seq_last),
        .q_count     (q_count),
        .push        (push),
        .push_sum    (push_sum),
        .push_count  (push_count),
        .push_sat    (push_sat)
    );

    sgba_queue #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_sum, push_count, push_sat}),
        .pop       (pop),
        .head_data (head_data),
        .empty     (q_empty),
        .count     (q_count)
    );

    sgba_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .head_sum        (head_data[QW-1:COUNT_BITS+1]),
        .head_count      (head_data[COUNT_BITS:1]),
        .head_sat        (head_data[0]),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .bias_mean       (bias_mean),
        .window_count    (window_count),
        .too_short       (too_short),
        .count_saturated (count_saturated)
    );

endmodule

@@ rtl/sgba_checker.sv @@
// Port-level checks on the result channel of the GC bias averager.
// Depends on sgba_pkg; bound to sliding_gc_bias_average below.
module sgba_checker
    import sgba_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  result_valid,
    input logic                  result_stall,
    input logic [MEAN_W-1:0]     bias_mean,
    input logic [COUNT_BITS-1:0] window_count,
    input logic                  too_short,
    input logic                  count_saturated
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && too_short |-> (bias_mean == '0) && (window_count == '0))
        else $error("short sequence with nonzero mean or count");

    a_short_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && too_short |-> !count_saturated)
        else $error("short sequence flagged saturated");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && count_saturated |-> (window_count == {COUNT_BITS{1'b1}}))
        else $error("saturation flag without full count");

endmodule

bind sliding_gc_bias_average sgba_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_sgba_checker (.*);
